FILE: hw/rtl/aesc_pkg.sv
// ----------------------------------------------------------------------------
// aesc_pkg: shared types and constants of the escape sequence stripper
// Byte codes of the filter, the escape mode encoding and the result bundle
// passed from the filter to the output queue.
// ----------------------------------------------------------------------------
package aesc_pkg;

   localparam logic [7:0] ESC_BYTE = 8'h1b;
   localparam logic [7:0] CSI_OPEN = 8'h5b;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7e;
   localparam logic [7:0] PROMPT_A = 8'h7e;
   localparam logic [7:0] PROMPT_B = 8'h24;
   localparam logic [7:0] PROMPT_C = 8'h20;
   localparam logic [7:0] CR_BYTE  = 8'h0d;

   localparam int unsigned LIMIT_W     = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

   // Held prompt byte counts
   localparam logic [1:0] HOLD_NONE  = 2'd0;
   localparam logic [1:0] HOLD_TILDE = 2'd1;
   localparam logic [1:0] HOLD_TWO   = 2'd2;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_CSI  = 2'd2
   } esc_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       empty;
      logic       last;
   } result_type;

   // Up to three results caused by one item
   typedef struct packed {
      logic [1:0]           cnt;
      result_type [2:0]     res;
   } burst_type;

endpackage

FILE: hw/rtl/aesc_filter.sv
// ----------------------------------------------------------------------------
// aesc_filter: per-byte filter step
// Holds escape mode, prompt match and passed byte count, and turns each
// accepted item into a burst of zero to three results.
// ----------------------------------------------------------------------------
module aesc_filter
   import aesc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   input  logic               item_fire,
   input  logic [7:0]         item_byte,
   input  logic               item_last,
   output burst_type          burst
);

   esc_mode_type       mode_ff, mode_in;
   logic [1:0]         hold_ff, hold_in;
   logic [LIMIT_W-1:0] passed_ff, passed_in;
   logic [LIMIT_W-1:0] limit_ff;

   logic       to_text;     // byte goes through ordinary text handling
   logic [1:0] pre_hold;    // held bytes released ahead of this byte
   logic       csi_enter;
   logic       csi_exit;
   logic [1:0] hold_step;   // hold count before the end-of-message flush
   logic       text_emit;

   logic [7:0]         cand [4];
   logic [1:0]         cand_n;
   logic [LIMIT_W-1:0] room;
   logic [1:0]         emit_n;

   // Classify the byte against the current mode and prompt match
   always_comb begin
      to_text   = 1'b0;
      pre_hold  = HOLD_NONE;
      csi_enter = 1'b0;
      csi_exit  = 1'b0;
      hold_step = hold_ff;
      unique case (mode_ff)
         MODE_ESC: begin
            if (item_byte == CSI_OPEN) begin
               csi_enter = 1'b1;
            end else begin
               to_text = 1'b1;
            end
         end
         MODE_CSI: begin
            csi_exit = (item_byte >= FINAL_LO) && (item_byte <= FINAL_HI);
         end
         default: begin
            priority if (hold_ff == HOLD_TILDE) begin
               if (item_byte == PROMPT_B) begin
                  hold_step = HOLD_TWO;
               end else begin
                  pre_hold = HOLD_TILDE;
                  to_text  = 1'b1;
               end
            end else if (hold_ff == HOLD_TWO) begin
               if (item_byte == PROMPT_C) begin
                  hold_step = HOLD_NONE;
               end else begin
                  pre_hold = HOLD_TWO;
                  to_text  = 1'b1;
               end
            end else begin
               to_text = 1'b1;
            end
         end
      endcase
      if (to_text) begin
         hold_step = (item_byte == PROMPT_A) ? HOLD_TILDE : HOLD_NONE;
      end
      text_emit = to_text && (item_byte != ESC_BYTE) && (item_byte != PROMPT_A) &&
                  (item_byte != CR_BYTE);
   end

   // Next escape mode and prompt hold
   always_comb begin
      if (csi_enter) begin
         mode_in = MODE_CSI;
      end else if (to_text && (item_byte == ESC_BYTE)) begin
         mode_in = MODE_ESC;
      end else if (mode_ff == MODE_CSI && !csi_exit) begin
         mode_in = MODE_CSI;
      end else begin
         mode_in = MODE_TEXT;
      end
      hold_in = hold_step;
      if (item_last) begin
         mode_in = MODE_TEXT;
         hold_in = HOLD_NONE;
      end
   end

   // Line up candidate bytes: released prompt, text byte, end flush
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cand[i] = PROMPT_A;
      end
      cand_n = 2'd0;
      if (pre_hold == HOLD_TILDE) begin
         cand_n = 2'd1;
      end else if (pre_hold == HOLD_TWO) begin
         cand[1] = PROMPT_B;
         cand_n  = 2'd2;
      end
      if (text_emit) begin
         cand[cand_n] = item_byte;
         cand_n       = cand_n + 2'd1;
      end
      if (item_last) begin
         if (hold_step == HOLD_TILDE) begin
            cand[cand_n] = PROMPT_A;
            cand_n       = cand_n + 2'd1;
         end else if (hold_step == HOLD_TWO) begin
            cand[0] = PROMPT_A;
            cand[1] = PROMPT_B;
            cand_n  = 2'd2;
         end
      end
   end

   // Clip to the per-message limit and build the burst
   always_comb begin
      room   = (passed_ff < limit_ff) ? (limit_ff - passed_ff) : '0;
      emit_n = (room < {{(LIMIT_W-2){1'b0}}, cand_n}) ? room[1:0] : cand_n;
      for (int i = 0; i < 3; i++) begin
         burst.res[i].data  = cand[i];
         burst.res[i].empty = 1'b0;
         burst.res[i].last  = item_last && (emit_n == 2'(i + 1));
      end
      burst.cnt = emit_n;
      if (item_last && emit_n == 2'd0) begin
         burst.res[0].data  = 8'h00;
         burst.res[0].empty = 1'b1;
         burst.res[0].last  = 1'b1;
         burst.cnt          = 2'd1;
      end
      passed_in = item_last ? '0 : passed_ff + {{(LIMIT_W-2){1'b0}}, emit_n};
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TEXT;
         hold_ff   <= HOLD_NONE;
         passed_ff <= '0;
      end else if (item_fire) begin
         mode_ff   <= mode_in;
         hold_ff   <= hold_in;
         passed_ff <= passed_in;
      end
   end

   // Hold the output limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

endmodule

FILE: hw/rtl/aesc_out_queue.sv
// ----------------------------------------------------------------------------
// aesc_out_queue: result register and short drain queue
// Loads up to three results; presents one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module aesc_out_queue
   import aesc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      load_ok,
   output logic      out_valid,
   input  logic      out_ready,
   output result_type out_res
);

   logic [1:0]  cnt_ff, cnt_in;
   result_type  res_ff [3];
   logic        drain;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_res   = res_ff[0];
   assign drain     = out_valid && out_ready;
   // Take a new burst once the queue empties this cycle
   assign load_ok   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && out_ready);

   always_comb begin
      if (load) begin
         cnt_in = burst.cnt;
      end else if (drain) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Load a burst or shift toward the head
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff[0] <= burst.res[0];
         res_ff[1] <= burst.res[1];
         res_ff[2] <= burst.res[2];
      end else if (drain) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
      end
   end

endmodule

FILE: hw/rtl/ansi_escape_stripper.sv
// ----------------------------------------------------------------------------
// ansi_escape_stripper: CSI escape, prompt and CR stripper for a byte stream
// Timing: the first result of an item appears in the cycle after it is accepted.
// Throughput: an item giving zero or one result is taken every cycle while
// rsp_tready is high; after one giving more (up to three), the next item
// is taken as the output queue, draining one result per ready cycle, empties.
// Reset: synchronous, clears mode, prompt match, count, queue; limit = 1023.
// ----------------------------------------------------------------------------
module ansi_escape_stripper
   import aesc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,   // out_limit
   // input items
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,     // [7:0] in_byte
   input  logic               req_tlast,     // in_last
   // results
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,     // [7:0] out_byte
   output logic               rsp_tuser,     // [0] out_empty
   output logic               rsp_tlast      // out_last
);

   logic       req_fire;
   logic       load_ok;
   burst_type  burst;
   result_type head;

   assign req_tready = load_ok;
   assign req_fire   = req_tvalid && load_ok;

   aesc_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_fire   (req_fire),
      .item_byte   (req_tdata),
      .item_last   (req_tlast),
      .burst       (burst)
   );

   aesc_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .burst     (burst),
      .load_ok   (load_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = head.data;
   assign rsp_tuser = head.empty;
   assign rsp_tlast = head.last;

endmodule
